@@ src/midpoint_circle_rasterizer_defines.svh @@
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer assertion macros
// Shared concurrent assertion forms, synchronous reset, active low.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mcr_pkg.sv @@
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Widths, opcodes and the job word passed from front end to back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcr_pkg;

    localparam int COORD_BITS = 11;
    localparam int OUT_BITS   = COORD_BITS + 2;
    localparam int DEC_BITS   = COORD_BITS + 5;
    localparam int Q_DEPTH    = 2;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_opcode;

    // One iteration of the walk: centre, current offsets, final flag.
    typedef struct packed {
        logic [COORD_BITS-1:0] h;
        logic [COORD_BITS-1:0] k;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  fin;
    } t_job;

endpackage

`default_nettype wire

@@ src/mcr_channels.sv @@
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer channels
// Valid/ready interfaces for the command input and the pixel output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mcr_in_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [mcr_pkg::COORD_BITS-1:0] center_x;
    logic [mcr_pkg::COORD_BITS-1:0] center_y;
    logic [mcr_pkg::COORD_BITS-1:0] radius;

    modport source (output valid, output opcode, output center_x, output center_y,
                    output radius, input ready);
    modport sink   (input valid, input opcode, input center_x, input center_y,
                    input radius, output ready);
endinterface

interface mcr_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [mcr_pkg::OUT_BITS-1:0] pixel_x;
    logic signed [mcr_pkg::OUT_BITS-1:0] pixel_y;
    logic                               last;

    modport source (output valid, output pixel_x, output pixel_y, output last,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input last,
                    output ready);
endinterface

`default_nettype wire

@@ src/mcr_front.sv @@
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer front end
// Accept commands, step the decision walk, queue one job per iteration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mcr_in_if.sink             i_in,
    output mcr_pkg::t_job      o_job,
    output logic               o_push,
    input  wire logic          i_q_ready
);

    localparam int CB = mcr_pkg::COORD_BITS;
    localparam int DB = mcr_pkg::DEC_BITS;

    logic [CB-1:0] r_x, r_y, r_h, r_k;
    logic [DB-1:0] r_d;
    logic          r_busy;

    logic [CB-1:0] cur_x, cur_y, cur_h, cur_k;
    logic [DB-1:0] cur_d, x_ext, y_ext;
    logic [DB-1:0] n_d;
    logic [CB-1:0] n_x, n_y;
    logic          is_start, d_neg, fin, accept;

    always_comb begin
        is_start = (mcr_pkg::t_opcode'(i_in.opcode) == mcr_pkg::OP_START);
        cur_x    = is_start ? '0 : r_x;
        cur_y    = is_start ? i_in.radius : r_y;
        cur_h    = is_start ? i_in.center_x : r_h;
        cur_k    = is_start ? i_in.center_y : r_k;
        cur_d    = is_start ? (DB'(3) - (DB'(i_in.radius) << 1)) : r_d;
        x_ext    = DB'(cur_x);
        y_ext    = DB'(cur_y);
        d_neg    = cur_d[DB-1];
        if (d_neg) begin
            n_d = cur_d + (x_ext << 2) + DB'(6);
            n_y = cur_y;
            fin = (cur_x >= cur_y);
        end else begin
            n_d = cur_d + ((x_ext - y_ext) << 2) + DB'(10);
            n_y = cur_y - CB'(1);
            fin = (({1'b0, cur_x} + (CB+1)'(1)) >= {1'b0, cur_y});
        end
        n_x = cur_x + CB'(1);
    end

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    // Drop an advance that arrives with no circle running.
    assign o_push     = accept && (is_start || r_busy);
    assign o_job      = '{h: cur_h, k: cur_k, x: cur_x, y: cur_y, fin: fin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_push) begin
            r_busy <= !fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_x <= n_x;
            r_y <= n_y;
            r_d <= n_d;
            r_h <= cur_h;
            r_k <= cur_k;
        end
    end

endmodule

`default_nettype wire

@@ src/mcr_queue.sv @@
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer job queue
// Two-entry FIFO decoupling the walk from pixel emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mcr_pkg::t_job i_job,
    output logic               o_ready,
    input  wire logic          i_pop,
    output mcr_pkg::t_job      o_job,
    output logic               o_valid
);

    localparam int PW = $clog2(mcr_pkg::Q_DEPTH);

    mcr_pkg::t_job r_mem [mcr_pkg::Q_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_count;

    assign o_ready = (r_count != (PW+1)'(mcr_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

@@ src/mcr_back.sv @@
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer back end
// Walk the eight symmetric pixels of the head job into an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "midpoint_circle_rasterizer_defines.svh"

module mcr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mcr_pkg::t_job i_job,
    input  wire logic          i_q_valid,
    output logic               o_pop,
    mcr_out_if.source          o_out
);

    localparam int OB = mcr_pkg::OUT_BITS;

    logic [2:0]          r_idx;
    logic                r_out_valid;
    logic signed [OB-1:0] r_px, r_py;
    logic                r_last;

    logic                load, swap, neg_a, neg_b;
    logic [OB-1:0]       a, b, hh, kk;
    logic signed [OB-1:0] n_px, n_py;

    assign load  = i_q_valid && (!r_out_valid || o_out.ready);
    assign o_pop = load && (r_idx == 3'd7);

    // Order: (+x,+y) (+y,+x) (+y,-x) (+x,-y) (-x,-y) (-y,-x) (-y,+x) (-x,+y)
    always_comb begin
        case (r_idx)
            3'd0:    begin swap = 1'b0; neg_a = 1'b0; neg_b = 1'b0; end
            3'd1:    begin swap = 1'b1; neg_a = 1'b0; neg_b = 1'b0; end
            3'd2:    begin swap = 1'b1; neg_a = 1'b0; neg_b = 1'b1; end
            3'd3:    begin swap = 1'b0; neg_a = 1'b0; neg_b = 1'b1; end
            3'd4:    begin swap = 1'b0; neg_a = 1'b1; neg_b = 1'b1; end
            3'd5:    begin swap = 1'b1; neg_a = 1'b1; neg_b = 1'b1; end
            3'd6:    begin swap = 1'b1; neg_a = 1'b1; neg_b = 1'b0; end
            default: begin swap = 1'b0; neg_a = 1'b1; neg_b = 1'b0; end
        endcase
        hh   = OB'(i_job.h);
        kk   = OB'(i_job.k);
        a    = swap ? OB'(i_job.y) : OB'(i_job.x);
        b    = swap ? OB'(i_job.x) : OB'(i_job.y);
        n_px = neg_a ? (hh - a) : (hh + a);
        n_py = neg_b ? (kk - b) : (kk + b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= r_idx + 3'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_last <= i_job.fin && (r_idx == 3'd7);
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.pixel_x = r_px;
    assign o_out.pixel_y = r_py;
    assign o_out.last    = r_last;

    `MCR_ASSERT_NOW(a_last_closes_job, i_clk, i_rst_n, r_out_valid && r_last, r_idx == 3'd0, "last word not at end of an iteration")
    `MCR_ASSERT_NOW(a_job_held, i_clk, i_rst_n, r_idx != 3'd0, i_q_valid, "job left the queue mid iteration")
    `MCR_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, r_out_valid && !o_out.ready, $stable(r_idx) && r_out_valid, "sequencer moved during a stall")

endmodule

`default_nettype wire

@@ src/midpoint_circle_rasterizer.sv @@
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// Bresenham midpoint circle walk with eight-way symmetric pixel output.
// ----------------------------------------------------------------------------
//  channel | dir | word contents                         | per command
//  i_in    | in  | opcode, center_x, center_y, radius    | one command
//  o_out   | out | pixel_x, pixel_y, last                | eight pixels
//
//  Each start or live advance yields eight words, one per cycle while the output
//  is ready; the sustained command rate is set by the single output port.
//  The first word passes two registers: the queue entry, written at the
//  accepting edge, then the output register, which loads once it is free.
//  Reset (i_rst_n low, synchronous) empties the queue and ends any circle.
//  A stalled output holds its word; the two-entry job queue lets commands
//  keep arriving until it fills, then i_in.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_rasterizer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mcr_in_if.sink    i_in,
    mcr_out_if.source o_out
);

    // Job word from the walk to the pixel sequencer
    mcr_pkg::t_job front_job;
    mcr_pkg::t_job head_job;
    logic          push, q_ready, q_valid, pop;

    // Front end: take commands, classify start/advance/drop, step the walk
    mcr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_job     (front_job),
        .o_push    (push),
        .i_q_ready (q_ready)
    );

    // Short queue so each side may stall on its own
    mcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_valid (q_valid)
    );

    // Back end: emit the eight symmetric pixels of the head job in order
    mcr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (head_job),
        .i_q_valid (q_valid),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

@@ verif/midpoint_circle_rasterizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer testbench
// Drives start and advance commands through the input channel, predicts the
// eight symmetric pixels of every walk iteration and checks each pixel word
// in order, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_test;

    localparam int CB = mcr_pkg::COORD_BITS;
    localparam int OB = mcr_pkg::OUT_BITS;

    typedef struct {
        mcr_pkg::t_opcode op;
        logic [CB-1:0]    cx;
        logic [CB-1:0]    cy;
        logic [CB-1:0]    rad;
    } t_circle_cmd;

    typedef struct {
        logic signed [OB-1:0] px;
        logic signed [OB-1:0] py;
        logic                 last;
    } t_plot_point;

    logic i_clk;
    logic i_rst_n;

    mcr_in_if  cmd_bus ();
    mcr_out_if pix_bus ();

    midpoint_circle_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_bus),
        .o_out   (pix_bus)
    );

    // Commands still to be offered, and pixel words still owed by the block.
    t_circle_cmd cmd_backlog[$];
    t_plot_point points_due[$];

    // Own copy of the circle walk.
    logic [CB-1:0] walk_h;
    logic [CB-1:0] walk_k;
    logic [CB-1:0] walk_x;
    logic [CB-1:0] walk_y;
    int            walk_d;
    bit            walk_busy;

    int mismatches  = 0;
    int words_seen  = 0;
    bit src_steady  = 0;
    bit snk_steady  = 0;
    int src_gap     = 0;
    int snk_gap     = 0;
    int hold_left   = 0;
    bit hold_done   = 0;

    // ------------------------------------------------------------------------
    // Clock and reset; every block input is known from time zero.
    // ------------------------------------------------------------------------
    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.opcode   = mcr_pkg::OP_START;
        cmd_bus.center_x = '0;
        cmd_bus.center_y = '0;
        cmd_bus.radius   = '0;
        pix_bus.ready    = 1'b0;
        walk_h           = '0;
        walk_k           = '0;
        walk_x           = '0;
        walk_y           = '0;
        walk_d           = 0;
        walk_busy        = 1'b0;
        fork
            forever #10 i_clk = ~i_clk;
            begin
                repeat (10) @(posedge i_clk);
                i_rst_n <= 1'b1;
            end
        join_none
    end

    // Most gaps are short, a few are long; a steady phase gives none at all.
    function automatic int next_gap(input bit steady);
        int pick;
        pick = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void add_cmd(input mcr_pkg::t_opcode op, input int cx, input int cy,
                                    input int rad);
        t_circle_cmd c;
        c.op  = op;
        c.cx  = CB'(cx);
        c.cy  = CB'(cy);
        c.rad = CB'(rad);
        cmd_backlog.push_back(c);
    endfunction

    function automatic void owe_point(input int px, input int py, input bit lst);
        t_plot_point p;
        p.px   = OB'(px);
        p.py   = OB'(py);
        p.last = lst;
        points_due.push_back(p);
    endfunction

    // ------------------------------------------------------------------------
    // One step of the walk: owe the eight octant pixels of the current
    // offsets, then move the decision value and the offsets on.
    // ------------------------------------------------------------------------
    function automatic void plot_octants();
        int h;
        int k;
        int ox;
        int oy;
        int ny;
        bit fin;
        h  = walk_h;
        k  = walk_k;
        ox = walk_x;
        oy = walk_y;
        ny = oy;
        if (walk_d < 0) begin
            walk_d = walk_d + 4 * ox + 6;
        end else begin
            walk_d = walk_d + 4 * (ox - oy) + 10;
            ny     = oy - 1;
        end
        fin = (ox + 1) > ny;

        owe_point(h + ox, k + oy, 1'b0);
        owe_point(h + oy, k + ox, 1'b0);
        owe_point(h + oy, k - ox, 1'b0);
        owe_point(h + ox, k - oy, 1'b0);
        owe_point(h - ox, k - oy, 1'b0);
        owe_point(h - oy, k - ox, 1'b0);
        owe_point(h - oy, k + ox, 1'b0);
        owe_point(h - ox, k + oy, fin);

        walk_x = CB'(ox + 1);
        walk_y = CB'(ny);
        if (fin)
            walk_busy = 1'b0;
    endfunction

    // A start reloads the walk (dropping any circle in flight); an advance
    // while idle owes nothing.
    function automatic void rasterize_cmd(input t_circle_cmd c);
        if (c.op == mcr_pkg::OP_START) begin
            walk_h    = c.cx;
            walk_k    = c.cy;
            walk_x    = '0;
            walk_y    = c.rad;
            walk_d    = 3 - 2 * int'(c.rad);
            walk_busy = 1'b1;
            plot_octants();
        end else if (walk_busy) begin
            plot_octants();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Command driver: offer the head of the backlog, hold it until taken,
    // then predict its pixels and idle for a random gap.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_cmds
        t_circle_cmd c;
        bit          offer;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                c = cmd_backlog.pop_front();
                rasterize_cmd(c);
                if ($urandom_range(0, 39) == 0)
                    src_steady = !src_steady;
                src_gap = next_gap(src_steady);
            end
            offer = 1'b0;
            if (cmd_bus.valid && !cmd_bus.ready)
                offer = 1'b1;
            else if (src_gap > 0)
                src_gap = src_gap - 1;
            else if (cmd_backlog.size() > 0)
                offer = 1'b1;
            cmd_bus.valid <= offer;
            if (offer) begin
                cmd_bus.opcode   <= cmd_backlog[0].op;
                cmd_bus.center_x <= cmd_backlog[0].cx;
                cmd_bus.center_y <= cmd_backlog[0].cy;
                cmd_bus.radius   <= cmd_backlog[0].rad;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel monitor: check every word taken against the oldest one owed, and
    // drive ready with random stalls. Once, hold ready low for a long stretch
    // so the job queue fills and the block pushes back on its input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_pixels
        t_plot_point want;
        if (!i_rst_n) begin
            pix_bus.ready <= 1'b0;
        end else begin
            if (pix_bus.valid && pix_bus.ready) begin
                words_seen = words_seen + 1;
                if (points_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: unexpected word: expected none, actual (%0d,%0d) last=%0b",
                             $time, pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.last);
                end else begin
                    want = points_due.pop_front();
                    if (pix_bus.pixel_x !== want.px) begin
                        mismatches = mismatches + 1;
                        $display("%0t: pixel_x mismatch: expected %0d, actual %0d",
                                 $time, want.px, pix_bus.pixel_x);
                    end
                    if (pix_bus.pixel_y !== want.py) begin
                        mismatches = mismatches + 1;
                        $display("%0t: pixel_y mismatch: expected %0d, actual %0d",
                                 $time, want.py, pix_bus.pixel_y);
                    end
                    if (pix_bus.last !== want.last) begin
                        mismatches = mismatches + 1;
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, pix_bus.last);
                    end
                end
            end

            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                pix_bus.ready <= 1'b0;
            end else if (!hold_done && words_seen >= 64) begin
                // long back-pressure stretch while the sender keeps offering
                hold_done = 1'b1;
                hold_left = 300;
                pix_bus.ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap = snk_gap - 1;
                pix_bus.ready <= 1'b0;
            end else begin
                pix_bus.ready <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    snk_steady = !snk_steady;
                if ($urandom_range(0, 2) == 0)
                    snk_gap = next_gap(snk_steady);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int stim_count;
        int pick;
        int rad;
        int est;
        int adv;
        int n;

        // Directed: idle advance, zero radius, coordinate extremes, start
        // while busy, a small circle walked to its end and beyond.
        add_cmd(mcr_pkg::OP_ADVANCE, 2047, 2047, 2047);
        add_cmd(mcr_pkg::OP_START, 0, 0, 0);
        add_cmd(mcr_pkg::OP_START, 2047, 2047, 0);
        add_cmd(mcr_pkg::OP_START, 0, 0, 1);
        add_cmd(mcr_pkg::OP_ADVANCE, 0, 0, 0);
        add_cmd(mcr_pkg::OP_START, 0, 0, 2047);
        add_cmd(mcr_pkg::OP_ADVANCE, 1365, 682, 1365);
        add_cmd(mcr_pkg::OP_ADVANCE, 682, 1365, 682);
        add_cmd(mcr_pkg::OP_ADVANCE, 0, 0, 0);
        add_cmd(mcr_pkg::OP_START, 2047, 2047, 2047);
        add_cmd(mcr_pkg::OP_ADVANCE, 0, 0, 0);
        add_cmd(mcr_pkg::OP_ADVANCE, 2047, 2047, 2047);
        add_cmd(mcr_pkg::OP_START, 1024, 1024, 5);
        for (n = 0; n < 6; n++)
            add_cmd(mcr_pkg::OP_ADVANCE, 0, 0, 0);
        add_cmd(mcr_pkg::OP_START, 0, 2047, 2047);
        add_cmd(mcr_pkg::OP_ADVANCE, 0, 0, 0);
        add_cmd(mcr_pkg::OP_START, 2047, 0, 1024);
        add_cmd(mcr_pkg::OP_ADVANCE, 0, 0, 0);

        // Random: mostly whole circles of small radius walked to the end,
        // some large ones abandoned early, plus stray advances.
        stim_count = 0;
        while (stim_count < 90) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    rad = $urandom_range(0, 24);
                else if (pick < 90)
                    rad = $urandom_range(25, 200);
                else
                    rad = $urandom_range(0, 2047);
                est = (rad * 181) / 256 + 1;
                if (rad > 40)
                    adv = $urandom_range(0, 10);
                else
                    adv = est - 1 + $urandom_range(0, 2);
                add_cmd(mcr_pkg::OP_START, $urandom_range(0, 2047), $urandom_range(0, 2047),
                        rad);
                for (n = 0; n < adv; n++)
                    add_cmd(mcr_pkg::OP_ADVANCE, $urandom_range(0, 2047),
                            $urandom_range(0, 2047), $urandom_range(0, 2047));
                stim_count = stim_count + 1 + ((adv < est - 1) ? adv : est - 1);
            end else if (pick < 90) begin
                adv = $urandom_range(1, 3);
                for (n = 0; n < adv; n++)
                    add_cmd(mcr_pkg::OP_ADVANCE, $urandom_range(0, 2047),
                            $urandom_range(0, 2047), $urandom_range(0, 2047));
            end else begin
                adv = $urandom_range(0, 3);
                add_cmd(mcr_pkg::OP_START, $urandom_range(0, 2047), $urandom_range(0, 2047),
                        $urandom_range(0, 2047));
                for (n = 0; n < adv; n++)
                    add_cmd(mcr_pkg::OP_ADVANCE, $urandom_range(0, 2047),
                            $urandom_range(0, 2047), $urandom_range(0, 2047));
                stim_count = stim_count + 1 + adv;
            end
        end

        // Wait for every command to be taken and every pixel to arrive,
        // then allow a short drain for anything stray.
        @(posedge i_clk);
        while (!i_rst_n || cmd_backlog.size() != 0 || points_due.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatches == 0)
            $display("[midpoint_circle_rasterizer] OK");
        else
            $display("[midpoint_circle_rasterizer] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("[midpoint_circle_rasterizer] ERROR");
        $finish;
    end

endmodule
